[hdl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sfd_pkg.sv]
// Types and constants of the sensor frame deframer.
package sfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 3'd0,
    CFG_TYPE_MARKER  = 3'd1,
    CFG_END_MARKER   = 3'd2,
    CFG_ACK_CODE     = 3'd3,
    CFG_OWN_SENSOR   = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_TYPE = 4'd1,
    PH_LEN  = 4'd2,
    PH_PID  = 4'd3,
    PH_SID  = 4'd4,
    PH_OPC  = 4'd5,
    PH_PAY  = 4'd6,
    PH_SUM  = 4'd7,
    PH_END  = 4'd8,
    PH_ASUM = 4'd9,
    PH_AEND = 4'd10
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_PAYLOAD = 4'd0,
    K_DATA_OK = 4'd1,
    K_ACK_OK  = 4'd2,
    K_SUM_ERR = 4'd3,
    K_END_ERR = 4'd4,
    K_UNKNOWN = 4'd5,
    K_START   = 4'd6,
    K_TYPE    = 4'd7,
    K_SHORT   = 4'd8
  } kind_t;

  localparam byte_t MIN_LENGTH = 8'd3;

  typedef struct packed {
    byte_t start_marker;
    byte_t type_marker;
    byte_t end_marker;
    byte_t ack_code;
    byte_t own_sensor;
  } cfg_regs_t;

  typedef struct packed {
    kind_t kind;
    logic  frame_is_ack;
    byte_t packet_number;
    byte_t source_id;
    byte_t command_code;
    byte_t frame_length;
    byte_t payload_byte;
  } result_t;

endpackage

[hdl/sfd_in_if.sv]
// Byte input channel.
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[hdl/sfd_out_if.sv]
// Result output channel.
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic       frame_is_ack;
  logic [7:0] packet_number;
  logic [7:0] source_id;
  logic [7:0] command_code;
  logic [7:0] frame_length;
  logic [7:0] payload_byte;

  modport source (output valid, output kind, output frame_is_ack, output packet_number,
                  output source_id, output command_code, output frame_length,
                  output payload_byte, input ready);
  modport sink (input valid, input kind, input frame_is_ack, input packet_number,
                input source_id, input command_code, input frame_length,
                input payload_byte, output ready);
endinterface

[hdl/sfd_cfg_if.sv]
// Configuration write channel.
interface sfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [7:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

[hdl/sfd_cfg_regs.sv]
// Configuration register file of the deframer.
module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  cfg_index_t  wr_index,
  input  byte_t       wr_data,
  output cfg_regs_t   regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_START_MARKER: regs.start_marker <= wr_data;
        CFG_TYPE_MARKER:  regs.type_marker  <= wr_data;
        CFG_END_MARKER:   regs.end_marker   <= wr_data;
        CFG_ACK_CODE:     regs.ack_code     <= wr_data;
        CFG_OWN_SENSOR:   regs.own_sensor   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/sfd_parser.sv]
// Frame parsing state machine: one byte per step, at most one result.
module sfd_parser
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  byte_t     rx_byte,
  input  cfg_regs_t cfg,
  output logic      emit,
  output result_t   result
);

  phase_t phase, phase_next;
  byte_t  length_seen, length_seen_next;
  byte_t  packet_seen, packet_seen_next;
  byte_t  source_seen, source_seen_next;
  byte_t  opcode_seen, opcode_seen_next;
  byte_t  running_sum, running_sum_next;
  byte_t  payload_left, payload_left_next;
  logic   sum_ok, sum_ok_next;
  logic   ack_frame, ack_frame_next;

  // Next state
  always_comb begin
    phase_next        = phase;
    length_seen_next  = length_seen;
    packet_seen_next  = packet_seen;
    source_seen_next  = source_seen;
    opcode_seen_next  = opcode_seen;
    running_sum_next  = running_sum;
    payload_left_next = payload_left;
    sum_ok_next       = sum_ok;
    ack_frame_next    = ack_frame;
    case (phase)
      PH_TYPE: begin
        phase_next = (rx_byte == cfg.type_marker) ? PH_LEN : PH_HUNT;
      end
      PH_LEN: begin
        length_seen_next = rx_byte;
        packet_seen_next = '0;
        source_seen_next = '0;
        opcode_seen_next = '0;
        ack_frame_next   = 1'b0;
        sum_ok_next      = 1'b0;
        phase_next       = PH_PID;
      end
      PH_PID: begin
        packet_seen_next = rx_byte;
        phase_next       = PH_SID;
      end
      PH_SID: begin
        source_seen_next = rx_byte;
        running_sum_next = length_seen + packet_seen + rx_byte;
        if (rx_byte == cfg.own_sensor) begin
          ack_frame_next = 1'b0;
          phase_next     = (length_seen < MIN_LENGTH) ? PH_HUNT : PH_OPC;
        end else if (rx_byte == cfg.ack_code) begin
          ack_frame_next = 1'b1;
          phase_next     = PH_ASUM;
        end else begin
          ack_frame_next = 1'b0;
          phase_next     = PH_HUNT;
        end
      end
      PH_OPC: begin
        opcode_seen_next  = rx_byte;
        running_sum_next  = running_sum + rx_byte;
        payload_left_next = length_seen - MIN_LENGTH;
        phase_next        = (length_seen == MIN_LENGTH) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        running_sum_next  = running_sum + rx_byte;
        payload_left_next = payload_left - 8'd1;
        if (payload_left == 8'd1) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        sum_ok_next = (rx_byte == running_sum);
        phase_next  = PH_END;
      end
      PH_ASUM: begin
        sum_ok_next = (rx_byte == running_sum);
        phase_next  = PH_AEND;
      end
      PH_END, PH_AEND: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (rx_byte == cfg.start_marker) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

  // Outputs: frame results carry the updated frame fields
  always_comb begin
    logic  bare;
    kind_t kind;
    bare = 1'b0;
    kind = K_PAYLOAD;
    emit = 1'b0;
    case (phase)
      PH_TYPE: begin
        emit = (rx_byte != cfg.type_marker);
        bare = 1'b1;
        kind = K_TYPE;
      end
      PH_LEN, PH_PID, PH_OPC, PH_SUM, PH_ASUM: begin
        emit = 1'b0;
      end
      PH_SID: begin
        if (rx_byte == cfg.own_sensor) begin
          emit = (length_seen < MIN_LENGTH);
          kind = K_SHORT;
        end else if (rx_byte == cfg.ack_code) begin
          emit = 1'b0;
        end else begin
          emit = 1'b1;
          kind = K_UNKNOWN;
        end
      end
      PH_PAY: begin
        emit = 1'b1;
        kind = K_PAYLOAD;
      end
      PH_END, PH_AEND: begin
        emit = 1'b1;
        if (rx_byte != cfg.end_marker) begin
          kind = K_END_ERR;
        end else if (!sum_ok) begin
          kind = K_SUM_ERR;
        end else begin
          kind = (phase == PH_END) ? K_DATA_OK : K_ACK_OK;
        end
      end
      default: begin
        emit = (rx_byte != cfg.start_marker);
        bare = 1'b1;
        kind = K_START;
      end
    endcase

    result.kind = kind;
    if (bare) begin
      result.frame_is_ack  = 1'b0;
      result.packet_number = '0;
      result.source_id     = '0;
      result.command_code  = '0;
      result.frame_length  = '0;
      result.payload_byte  = '0;
    end else begin
      result.frame_is_ack  = ack_frame_next;
      result.packet_number = packet_seen_next;
      result.source_id     = source_seen_next;
      result.command_code  = ack_frame_next ? '0 : opcode_seen_next;
      result.frame_length  = length_seen_next;
      result.payload_byte  = (kind == K_PAYLOAD) ? rx_byte : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      length_seen  <= '0;
      packet_seen  <= '0;
      source_seen  <= '0;
      opcode_seen  <= '0;
      running_sum  <= '0;
      payload_left <= '0;
      sum_ok       <= 1'b0;
      ack_frame    <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      length_seen  <= length_seen_next;
      packet_seen  <= packet_seen_next;
      source_seen  <= source_seen_next;
      opcode_seen  <= opcode_seen_next;
      running_sum  <= running_sum_next;
      payload_left <= payload_left_next;
      sum_ok       <= sum_ok_next;
      ack_frame    <= ack_frame_next;
    end
  end

endmodule

[hdl/sfd_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
module sfd_out_buf
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  input  logic    pop_ready,
  output logic    head_valid,
  output result_t head_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop      = head_valid && pop_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        // advance skid into head
        head_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        head_data <= push_data;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_data  <= push_data;
        head_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

[hdl/sensor_frame_deframer_top.sv]
// Sensor frame deframer: accepts one stream byte per cycle while rx.ready is high and reports frame events.
//
// Channels: rx carries received bytes, res carries results (payload bytes and
// one closing status per frame), cfg writes the five marker/id registers by index.
// An item moves on a transaction, when valid and ready are both high at a rising edge.
// Each accepted byte yields zero or one result. A result is registered in the output
// buffer when its byte is accepted and shows on res once the results ahead of it drain.
// Throughput is one byte per cycle while rx.ready is high: the parser state machine and
// its 8-bit adder handle each byte combinationally, and a two-entry output buffer (output
// register plus skid register) lets rx take a byte while res is stalled and the skid is free.
// When the receiver stalls, rx.ready drops once the skid entry is used and
// rises again in the cycle after res drains an entry.
// Reset (rst, synchronous) clears the parser and configuration registers to zero, puts the
// parser into start-marker hunting and empties the result buffer. cfg.ready is always high and
// writes take effect on the next byte; writes to an index past the list are dropped.
module sensor_frame_deframer_top
  import sfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  sfd_in_if.sink    rx,
  sfd_out_if.source res,
  sfd_cfg_if.sink   cfg
);

`include "assert_macros.svh"

  cfg_regs_t cfg_regs;
  logic      rx_accept;
  logic      emit;
  logic      push;
  logic      can_push;
  result_t   parsed;
  result_t   head_data;

  assign cfg.ready = 1'b1;
  assign rx.ready  = can_push;
  assign rx_accept = rx.valid && can_push;
  assign push      = rx_accept && emit;

  sfd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg_index_t'(cfg.reg_index)),
    .wr_data  (cfg.wr_data),
    .regs     (cfg_regs)
  );

  sfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (rx_accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg_regs),
    .emit    (emit),
    .result  (parsed)
  );

  sfd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (parsed),
    .can_push   (can_push),
    .pop_ready  (res.ready),
    .head_valid (res.valid),
    .head_data  (head_data)
  );

  assign res.kind          = head_data.kind;
  assign res.frame_is_ack  = head_data.frame_is_ack;
  assign res.packet_number = head_data.packet_number;
  assign res.source_id     = head_data.source_id;
  assign res.command_code  = head_data.command_code;
  assign res.frame_length  = head_data.frame_length;
  assign res.payload_byte  = head_data.payload_byte;

  `SFD_ASSERT_NXT(a_push_shows_result, clk, rst, push, res.valid, "pushed result not shown")
  `SFD_ASSERT_IMP(a_full_implies_valid, clk, rst, !rx.ready, res.valid,
                  "buffer full with no visible result")
  `SFD_ASSERT_IMP(a_status_no_payload, clk, rst,
                  res.valid && (res.kind != K_PAYLOAD), res.payload_byte == 8'd0,
                  "status result carries payload")

endmodule

[sim/tb_sensor_frame_deframer_top.sv]
// Self-checking testbench for the sensor frame deframer: random byte streams against a predictor.
module tb_sensor_frame_deframer_top;
  import sfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_BAD_END} flaw_t;

  localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd7;
  localparam int unsigned LONG_HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_in_if  rx_ch ();
  sfd_out_if res_ch ();
  sfd_cfg_if cfg_ch ();

  logic                 drv_valid = 1'b0;
  byte_t                drv_byte = '0;
  logic                 res_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  byte_t                cfg_data = '0;

  assign rx_ch.valid   = drv_valid;
  assign rx_ch.rx_byte = drv_byte;
  assign res_ch.ready  = res_ready;
  assign cfg_ch.valid  = cfg_valid;
  assign cfg_ch.reg_index = cfg_idx;
  assign cfg_ch.wr_data   = cfg_data;

  sensor_frame_deframer_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus side
  byte_t     tx_bytes[$];
  cfg_regs_t regs_cur = '0;
  int        bytes_queued = 0;
  int        settings_used = 0;
  logic      byte_taken = 1'b0;
  logic      no_gaps = 1'b0;
  logic      hold_off_req = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;

  // Predictor state and register copy
  cfg_regs_t regs_seen = '0;
  phase_t    ph = PH_HUNT;
  byte_t     len_q = '0, pid_q = '0, sid_q = '0, opc_q = '0, sum_q = '0, left_q = '0;
  logic      sum_good = 1'b0, is_ack = 1'b0;
  result_t   pending_reports[$];

  int mismatch_count = 0;
  int reports_checked = 0;
  int good_frames = 0;

  function automatic void deframe_byte(byte_t b);
    result_t r;
    logic    emit;
    logic    bare;
    kind_t   k;
    r = '0;
    emit = 1'b0;
    bare = 1'b0;
    k = K_PAYLOAD;
    case (ph)
      PH_TYPE: begin
        if (b == regs_seen.type_marker) begin
          ph = PH_LEN;
        end else begin
          ph = PH_HUNT;
          emit = 1'b1;
          bare = 1'b1;
          k = K_TYPE;
        end
      end
      PH_LEN: begin
        len_q = b;
        pid_q = '0;
        sid_q = '0;
        opc_q = '0;
        is_ack = 1'b0;
        sum_good = 1'b0;
        ph = PH_PID;
      end
      PH_PID: begin
        pid_q = b;
        ph = PH_SID;
      end
      PH_SID: begin
        sid_q = b;
        sum_q = len_q + pid_q + b;
        // own id wins when it also equals the ack code
        if (b == regs_seen.own_sensor) begin
          is_ack = 1'b0;
          if (len_q < MIN_LENGTH) begin
            ph = PH_HUNT;
            emit = 1'b1;
            k = K_SHORT;
          end else begin
            ph = PH_OPC;
          end
        end else if (b == regs_seen.ack_code) begin
          is_ack = 1'b1;
          ph = PH_ASUM;
        end else begin
          is_ack = 1'b0;
          ph = PH_HUNT;
          emit = 1'b1;
          k = K_UNKNOWN;
        end
      end
      PH_OPC: begin
        opc_q = b;
        sum_q = sum_q + b;
        left_q = len_q - MIN_LENGTH;
        ph = (left_q == 0) ? PH_SUM : PH_PAY;
      end
      PH_PAY: begin
        sum_q = sum_q + b;
        left_q = left_q - 1'b1;
        if (left_q == 0) ph = PH_SUM;
        emit = 1'b1;
        k = K_PAYLOAD;
      end
      PH_SUM, PH_ASUM: begin
        sum_good = (b == sum_q);
        ph = (ph == PH_SUM) ? PH_END : PH_AEND;
      end
      PH_END, PH_AEND: begin
        if (b != regs_seen.end_marker) k = K_END_ERR;
        else if (!sum_good) k = K_SUM_ERR;
        else k = (ph == PH_END) ? K_DATA_OK : K_ACK_OK;
        ph = PH_HUNT;
        emit = 1'b1;
      end
      default: begin
        if (b == regs_seen.start_marker) begin
          ph = PH_TYPE;
        end else begin
          ph = PH_HUNT;
          emit = 1'b1;
          bare = 1'b1;
          k = K_START;
        end
      end
    endcase
    if (emit) begin
      r.kind = k;
      if (!bare) begin
        r.frame_is_ack  = is_ack;
        r.packet_number = pid_q;
        r.source_id     = sid_q;
        r.command_code  = is_ack ? 8'h00 : opc_q;
        r.frame_length  = len_q;
        r.payload_byte  = (k == K_PAYLOAD) ? b : 8'h00;
      end
      pending_reports.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Sample at the rising edge: results first, then the accepted byte, then register writes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs_seen = '0;
      ph = PH_HUNT;
      len_q = '0; pid_q = '0; sid_q = '0; opc_q = '0; sum_q = '0; left_q = '0;
      sum_good = 1'b0;
      is_ack = 1'b0;
      pending_reports.delete();
      byte_taken = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   res_ch.kind);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("kind", 8'(want.kind), 8'(res_ch.kind));
          check_field("frame_is_ack", 8'(want.frame_is_ack), 8'(res_ch.frame_is_ack));
          check_field("packet_number", want.packet_number, res_ch.packet_number);
          check_field("source_id", want.source_id, res_ch.source_id);
          check_field("command_code", want.command_code, res_ch.command_code);
          check_field("frame_length", want.frame_length, res_ch.frame_length);
          check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
          reports_checked++;
          if (want.kind == K_DATA_OK || want.kind == K_ACK_OK) good_frames++;
        end
      end
      if (rx_ch.valid && rx_ch.ready) deframe_byte(rx_ch.rx_byte);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_START_MARKER: regs_seen.start_marker = cfg_ch.wr_data;
          CFG_TYPE_MARKER:  regs_seen.type_marker  = cfg_ch.wr_data;
          CFG_END_MARKER:   regs_seen.end_marker   = cfg_ch.wr_data;
          CFG_ACK_CODE:     regs_seen.ack_code     = cfg_ch.wr_data;
          CFG_OWN_SENSOR:   regs_seen.own_sensor   = cfg_ch.wr_data;
          default: ;
        endcase
      end
      byte_taken = rx_ch.valid && rx_ch.ready;
    end
  end

  // Byte sender: hold until the transaction completes, then advance or idle
  always @(negedge clk) begin
    if (!drv_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (tx_bytes.size() > 0) begin
        drv_valid <= 1'b1;
        drv_byte <= tx_bytes.pop_front();
        if (!no_gaps && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 8);
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_off_req) begin
      stall_left = LONG_HOLD_CYCLES;
      hold_off_req = 1'b0;
    end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  function automatic void queue_byte(byte_t b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void queue_frame(logic as_ack, byte_t len, flaw_t flaw);
    byte_t pid;
    byte_t sid;
    byte_t sum;
    byte_t v;
    pid = byte_t'($urandom);
    sid = as_ack ? regs_cur.ack_code : regs_cur.own_sensor;
    queue_byte(regs_cur.start_marker);
    queue_byte(regs_cur.type_marker);
    queue_byte(len);
    queue_byte(pid);
    queue_byte(sid);
    sum = len + pid + sid;
    if (!as_ack) begin
      for (int i = 2; i < int'(len); i++) begin
        v = byte_t'($urandom);
        queue_byte(v);
        sum = sum + v;
      end
    end
    if (flaw == FRAME_BAD_SUM) sum = sum ^ byte_t'($urandom_range(1, 255));
    queue_byte(sum);
    if (flaw == FRAME_BAD_END) queue_byte(regs_cur.end_marker ^ byte_t'($urandom_range(1, 255)));
    else queue_byte(regs_cur.end_marker);
  endfunction

  function automatic byte_t queue_len_for(kind_t what);
    return (what == K_SHORT) ? byte_t'($urandom_range(0, 2)) : byte_t'($urandom);
  endfunction

  // Broken sequences, named by the report each one should draw
  function automatic void queue_misfit(kind_t what);
    byte_t v;
    if (what == K_START) begin
      do v = byte_t'($urandom); while (v == regs_cur.start_marker);
      queue_byte(v);
    end else begin
      queue_byte(regs_cur.start_marker);
      if (what == K_TYPE) begin
        do v = byte_t'($urandom); while (v == regs_cur.type_marker);
        queue_byte(v);
      end else begin
        queue_byte(queue_len_for(what));
        queue_byte(byte_t'($urandom));
        if (what == K_SHORT) begin
          queue_byte(regs_cur.own_sensor);
        end else begin
          do v = byte_t'($urandom);
          while (v == regs_cur.own_sensor || v == regs_cur.ack_code);
          queue_byte(v);
        end
      end
    end
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 9);
    return (r == 0) ? FRAME_BAD_SUM : (r == 1) ? FRAME_BAD_END : FRAME_CLEAN;
  endfunction

  task automatic queue_random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        queue_frame(1'b0, ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(3, 24))
                                                      : byte_t'($urandom_range(3, 7)),
                    pick_flaw());
      end else if (pick < 70) begin
        queue_frame(1'b1, byte_t'($urandom), pick_flaw());
      end else if (pick < 76) begin
        queue_misfit(K_SHORT);
      end else if (pick < 82) begin
        queue_misfit(K_UNKNOWN);
      end else if (pick < 88) begin
        queue_misfit(K_TYPE);
      end else begin
        queue_misfit(K_START);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, byte_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_START_MARKER: regs_cur.start_marker = val;
      CFG_TYPE_MARKER:  regs_cur.type_marker  = val;
      CFG_END_MARKER:   regs_cur.end_marker   = val;
      CFG_ACK_CODE:     regs_cur.ack_code     = val;
      CFG_OWN_SENSOR:   regs_cur.own_sensor   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(byte_t sm, byte_t tm, byte_t em, byte_t ac, byte_t own);
    write_reg(CFG_START_MARKER, sm);
    write_reg(CFG_TYPE_MARKER, tm);
    write_reg(CFG_END_MARKER, em);
    write_reg(CFG_ACK_CODE, ac);
    write_reg(CFG_OWN_SENSOR, own);
    settings_used++;
  endtask

  task automatic set_random_config();
    byte_t ac;
    byte_t own;
    ac = byte_t'($urandom);
    do own = byte_t'($urandom); while (own == ac);
    set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), ac, own);
  endtask

  // Drain everything in flight, then allow the latency of a byte with no result
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || drv_valid) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    byte_t shared;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset register values: all markers and ids are zero
    settings_used = 1;
    queue_frame(1'b0, MIN_LENGTH, FRAME_CLEAN);
    wait_idle();

    set_config(8'hA5, 8'h5A, 8'h7E, 8'h01, 8'hFE);
    queue_misfit(K_START);
    queue_misfit(K_TYPE);
    queue_misfit(K_UNKNOWN);
    queue_byte(regs_cur.start_marker);
    queue_byte(regs_cur.type_marker);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(regs_cur.own_sensor);
    queue_frame(1'b1, 8'hFF, FRAME_CLEAN);
    wait_idle();

    // Write past the register list; must leave the setting alone
    write_reg(SPARE_REG_IDX, 8'hA5);
    queue_random_traffic(130);
    hold_off_req = 1'b1;
    wait_idle();

    set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_random_traffic(130);
    wait_idle();

    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_random_traffic(130);
    wait_idle();

    shared = byte_t'($urandom);
    set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom), shared, shared);
    queue_random_traffic(130);
    wait_idle();

    set_random_config();
    queue_frame(1'b0, 8'hFF, FRAME_CLEAN);
    queue_random_traffic(130);
    wait_idle();

    set_random_config();
    queue_random_traffic(130);
    wait_idle();

    set_random_config();
    no_gaps = 1'b1;
    queue_random_traffic(130);
    wait_idle();

    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_reports.size());
      mismatch_count++;
    end
    $display("Sent %0d stream bytes under %0d register settings.", bytes_queued, settings_used);
    $display("Checked %0d results, %0d of them frames closed as good.", reports_checked,
             good_frames);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule
